// ----- sv/tle_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tabu list engine package
// Shared types, codes and helpers for the tabu list engine and its cells.
// ----------------------------------------------------------------------------
package tle_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 64;
	localparam int unsigned POS_BITS       = 12;
	localparam int unsigned VAL_BITS       = 16;
	localparam int unsigned ITER_BITS      = 32;
	localparam int unsigned TENURE_BITS    = 6;
	localparam int unsigned COUNT_BITS     = 7;
	localparam int unsigned CFG_IDX_BITS   = 2;

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_ACCEPT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TENURE_MIN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TENURE_MAX = 2'd1;

	localparam logic [TENURE_BITS-1:0] TENURE_MIN_RST = 6'd5;
	localparam logic [TENURE_BITS-1:0] TENURE_MAX_RST = 6'd15;

	typedef struct packed {
		logic [1:0]             operation;
		logic [ITER_BITS-1:0]   iteration;
		logic [1:0]             component_count;
		logic [POS_BITS-1:0]    first_position;
		logic [VAL_BITS-1:0]    first_value;
		logic [POS_BITS-1:0]    second_position;
		logic [VAL_BITS-1:0]    second_value;
		logic [TENURE_BITS-1:0] tenure_draw;
	} tle_item_t;

	typedef struct packed {
		logic                  is_tabu;
		logic                  dropped_oldest;
		logic [COUNT_BITS-1:0] entry_count;
	} tle_result_t;

	typedef struct packed {
		logic                 two;
		logic [POS_BITS-1:0]  pos0;
		logic [VAL_BITS-1:0]  val0;
		logic [POS_BITS-1:0]  pos1;
		logic [VAL_BITS-1:0]  val1;
		logic [ITER_BITS-1:0] expiry;
	} tle_entry_t;

	typedef struct packed {
		logic shift;
		logic probe;
	} tle_cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_STORE,
		ST_POP,
		ST_REPORT
	} tle_state_t;

	function automatic logic tle_has(input tle_entry_t e, input logic [POS_BITS-1:0] p,
			input logic [VAL_BITS-1:0] v);
		logic m0;
		logic m1;
		m0 = (e.pos0 == p) && (e.val0 == v);
		m1 = e.two && (e.pos1 == p) && (e.val1 == v);
		return m0 || m1;
	endfunction

endpackage
`default_nettype wire

// ----- sv/tabu_list_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tabu list engine
// FIFO of recent moves held in a chain of cells, with per-cell match and
// expiry checks for tabu queries.
// ----------------------------------------------------------------------------
// One item is taken at a time; busy is high while it is in work. A query
// goes through probe and report, a clear or an unused code straight to
// report, and an accept through store, pop and report. In pop the front
// is retired one entry per cycle while expired, up to LIST_DEPTH - 1
// entries, as the new entry never expires at its own iteration. Every item
// produces one result on result, flagged by done for a single cycle; it
// cannot be held off and must be captured then.
// Newest entries enter at cell 0 and shift toward the last cell; on a push
// to a full list the last cell's entry falls off. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be issued while idle.
// ----------------------------------------------------------------------------
module tabu_list_engine #(
	parameter int unsigned LIST_DEPTH = tle_pkg::LIST_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire tle_pkg::tle_item_t             item,
	output logic                                done,
	output tle_pkg::tle_result_t                result,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [tle_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire [tle_pkg::TENURE_BITS-1:0]      cfg_data
);

	localparam int unsigned OCC_W = $clog2(LIST_DEPTH + 1);
	localparam int unsigned CW    = tle_pkg::COUNT_BITS;
	localparam int unsigned TW    = tle_pkg::TENURE_BITS;
	localparam int unsigned IW    = tle_pkg::ITER_BITS;

	tle_pkg::tle_state_t    state_q;
	tle_pkg::tle_state_t    state_d;
	tle_pkg::tle_item_t     item_q;
	tle_pkg::tle_result_t   res_q;
	tle_pkg::tle_cell_ctl_t ctl;
	tle_pkg::tle_entry_t    new_entry;
	tle_pkg::tle_entry_t    link [LIST_DEPTH];

	logic [OCC_W-1:0]      occ_q;
	logic [OCC_W+CW-1:0]   occ_ext;
	logic [TW-1:0]         tmin_q;
	logic [TW-1:0]         tmax_q;
	logic [TW-1:0]         t_lo;
	logic [TW-1:0]         tenure;
	logic [IW:0]           exp_sum;
	logic                  drop_q;
	logic                  done_q;
	logic [LIST_DEPTH-1:0] hit_vec;
	logic [LIST_DEPTH-1:0] fexp_vec;
	logic                  hit_any;
	logic                  front_exp;

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;
	assign hit_any   = |hit_vec;
	assign front_exp = |fexp_vec;
	assign occ_ext   = {{CW{1'b0}}, occ_q};

	// tenure clamp: raise to min first, then lower to max
	assign t_lo    = (item_q.tenure_draw < tmin_q) ? tmin_q : item_q.tenure_draw;
	assign tenure  = (t_lo > tmax_q) ? tmax_q : t_lo;
	assign exp_sum = {1'b0, item_q.iteration} + (IW + 1)'(tenure);

	always_comb begin
		new_entry.two    = item_q.component_count[1];
		new_entry.pos0   = item_q.first_position;
		new_entry.val0   = item_q.first_value;
		new_entry.pos1   = new_entry.two ? item_q.second_position : '0;
		new_entry.val1   = new_entry.two ? item_q.second_value : '0;
		new_entry.expiry = exp_sum[IW] ? {IW{1'b1}} : exp_sum[IW-1:0];
	end

	assign link[0] = new_entry;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		if (i < LIST_DEPTH - 1) begin : g_mid
			tle_cell #(
				.IDX   (i),
				.OCC_W (OCC_W)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl),
				.entry_in      (link[i]),
				.entry_out     (link[i+1]),
				.occ           (occ_q),
				.query         (item_q),
				.hit_q         (hit_vec[i]),
				.front_expired (fexp_vec[i])
			);
		end else begin : g_last
			tle_cell #(
				.IDX   (i),
				.OCC_W (OCC_W)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl),
				.entry_in      (link[i]),
				.entry_out     (),
				.occ           (occ_q),
				.query         (item_q),
				.hit_q         (hit_vec[i]),
				.front_expired (fexp_vec[i])
			);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tle_pkg::ST_IDLE: begin
				if (start) begin
					case (item.operation)
						tle_pkg::OP_QUERY:  state_d = tle_pkg::ST_PROBE;
						tle_pkg::OP_ACCEPT: state_d = tle_pkg::ST_STORE;
						default:            state_d = tle_pkg::ST_REPORT;
					endcase
				end
			end
			tle_pkg::ST_PROBE:  state_d = tle_pkg::ST_REPORT;
			tle_pkg::ST_STORE:  state_d = tle_pkg::ST_POP;
			tle_pkg::ST_POP: begin
				if (!front_exp) begin
					state_d = tle_pkg::ST_REPORT;
				end
			end
			tle_pkg::ST_REPORT: state_d = tle_pkg::ST_IDLE;
			default:            state_d = tle_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		ctl.shift = 1'b0;
		ctl.probe = 1'b0;
		case (state_q)
			tle_pkg::ST_IDLE:  busy = 1'b0;
			tle_pkg::ST_PROBE: ctl.probe = 1'b1;
			tle_pkg::ST_STORE: ctl.shift = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tle_pkg::ST_IDLE;
			occ_q   <= '0;
			tmin_q  <= tle_pkg::TENURE_MIN_RST;
			tmax_q  <= tle_pkg::TENURE_MAX_RST;
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == tle_pkg::ST_REPORT;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tle_pkg::CFG_TENURE_MIN: tmin_q <= cfg_data;
					tle_pkg::CFG_TENURE_MAX: tmax_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				tle_pkg::ST_IDLE: begin
					if (start) begin
						drop_q <= 1'b0;
						if (item.operation == tle_pkg::OP_CLEAR) begin
							occ_q <= '0;
						end
					end
				end
				tle_pkg::ST_STORE: begin
					if (occ_q == OCC_W'(LIST_DEPTH)) begin
						drop_q <= 1'b1;
					end else begin
						occ_q <= occ_q + 1'b1;
					end
				end
				tle_pkg::ST_POP: begin
					if (front_exp) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		if (state_q == tle_pkg::ST_REPORT) begin
			res_q.is_tabu        <= (item_q.operation == tle_pkg::OP_QUERY) && hit_any;
			res_q.dropped_oldest <= drop_q;
			res_q.entry_count    <= occ_ext[CW-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- sv/tle_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tabu list cell
// Holds one list entry, passes it to the next cell on a push, and checks it
// against the current query and the current iteration.
// ----------------------------------------------------------------------------
module tle_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned OCC_W = 7
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire tle_pkg::tle_cell_ctl_t ctl,
	input  wire tle_pkg::tle_entry_t    entry_in,
	output tle_pkg::tle_entry_t         entry_out,
	input  wire [OCC_W-1:0]             occ,
	input  wire tle_pkg::tle_item_t     query,
	output logic                        hit_q,
	output logic                        front_expired
);

	tle_pkg::tle_entry_t entry_q;
	logic                valid;
	logic                front;
	logic                expired;
	logic                has0;
	logic                has1;
	logic                hit_d;

	assign valid   = occ > OCC_W'(IDX);
	assign front   = occ == OCC_W'(IDX + 1);
	assign expired = query.iteration > entry_q.expiry;
	assign has0    = tle_pkg::tle_has(entry_q, query.first_position, query.first_value);
	assign has1    = tle_pkg::tle_has(entry_q, query.second_position, query.second_value);
	assign hit_d   = valid && !expired && (has0 || (query.component_count[1] && has1));

	assign front_expired = valid && front && expired;
	assign entry_out     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.probe) begin
			hit_q <= hit_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/tle_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tabu list engine checker
// Port-level checks on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module tle_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                start,
	input wire                                busy,
	input wire                                done,
	input wire tle_pkg::tle_result_t          result
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in work");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_tabu && result.dropped_oldest))
		else $error("tabu and drop flags both set");

endmodule

bind tabu_list_engine tle_checker u_tle_checker (.*);
`default_nettype wire
